@@ hw/rtl/multi_server_fifo_dispatcher_core_assert.svh @@
// Assertion macros shared by the dispatcher checker
`ifndef MULTI_SERVER_FIFO_DISPATCHER_CORE_ASSERT_SVH
`define MULTI_SERVER_FIFO_DISPATCHER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define MSFD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define MSFD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/msfd_pkg.sv @@
// Shared constants and types for the multi-server dispatcher
package msfd_pkg;

    localparam int DEF_MAX_SERVERS = 16;

    localparam int TIME_W      = 32;
    localparam int SVC_W       = 16;
    localparam int CNT_W       = 16;
    localparam int SUM_W       = 48;
    localparam int IDX_OUT_W   = 4;
    localparam int CFG_W       = 5;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 200;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic load_in;   // capture a new item, clear the scan trackers
        logic rd_en;     // read one server entry at the scan address
        logic calc;      // settle current time and chosen server
        logic commit;    // form end time, wait and new served count
        logic finish;    // write back state and load the result register
    } t_cmd;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic out_free;  // result register can take a new result this cycle
    } t_sts;

    // One result item
    typedef struct packed {
        logic [IDX_OUT_W-1:0] server_index;
        logic [TIME_W-1:0]    start_time;
        logic [TIME_W-1:0]    job_wait;
        logic [CNT_W-1:0]     server_jobs;
        logic [SUM_W-1:0]     total_wait;
        logic [TIME_W-1:0]    max_wait;
        logic [TIME_W-1:0]    finish_time;
    } t_result;

endpackage

@@ hw/rtl/msfd_ctrl.sv @@
// Sequencer: accepts an item, scans the server table, then steps the update
module msfd_ctrl #(
    parameter int MAX_SERVERS = msfd_pkg::DEF_MAX_SERVERS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [((MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1)-1:0] i_last,
    output msfd_pkg::t_cmd        o_cmd,
    output logic [((MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1)-1:0] o_rd_addr,
    input  msfd_pkg::t_sts        i_sts
);

    localparam int IDXW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_CALC,
        S_COMMIT,
        S_FINISH
    } t_state;

    t_state            r_state, n_state;
    logic [IDXW-1:0]   r_cnt, n_cnt;

    // Next state and scan counter
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SCAN;
                    n_cnt   = '0;
                end
            end
            S_SCAN: begin
                if (r_cnt == i_last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DRAIN:  n_state = S_CALC;
            S_CALC:   n_state = S_COMMIT;
            S_COMMIT: n_state = S_FINISH;
            S_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Commands decoded from the state
    always_comb begin
        o_cmd         = '0;
        o_cmd.load_in = (r_state == S_IDLE) && i_in_valid;
        o_cmd.rd_en   = (r_state == S_SCAN);
        o_cmd.calc    = (r_state == S_CALC);
        o_cmd.commit  = (r_state == S_COMMIT);
        o_cmd.finish  = (r_state == S_FINISH) && i_sts.out_free;
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_rd_addr  = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

@@ hw/rtl/msfd_dp.sv @@
// Datapath: server table, scan trackers, running totals and result register
module msfd_dp #(
    parameter int MAX_SERVERS = msfd_pkg::DEF_MAX_SERVERS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  msfd_pkg::t_cmd                i_cmd,
    input  logic [((MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1)-1:0] i_rd_addr,
    input  logic [msfd_pkg::TIME_W-1:0]   i_arrival_time,
    input  logic [msfd_pkg::SVC_W-1:0]    i_service_time,
    output msfd_pkg::t_sts                o_sts,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output msfd_pkg::t_result             o_res
);

    localparam int IDXW   = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int TIME_W = msfd_pkg::TIME_W;
    localparam int CNT_W  = msfd_pkg::CNT_W;
    localparam int SUM_W  = msfd_pkg::SUM_W;
    localparam int SVC_W  = msfd_pkg::SVC_W;

    // Server table
    logic [TIME_W-1:0]      mem_free [MAX_SERVERS];
    logic [CNT_W-1:0]       mem_cnt  [MAX_SERVERS];
    logic [MAX_SERVERS-1:0] r_valid;

    // Item and scan registers
    logic [TIME_W-1:0] r_arr, r_t;
    logic [SVC_W-1:0]  r_svc;
    logic [TIME_W-1:0] r_rd_free;
    logic [CNT_W-1:0]  r_rd_cnt;
    logic              r_rd_vbit, r_rd_vld;
    logic [IDXW-1:0]   r_rd_idx;
    logic              r_have_min, r_found;
    logic [TIME_W-1:0] r_min;
    logic [IDXW-1:0]   r_min_idx, r_free_idx, r_pick;
    logic [CNT_W-1:0]  r_min_cnt, r_free_cnt, r_cnt, r_cnt_new;
    logic [TIME_W-1:0] r_end, r_wait;

    // Architectural state
    logic [TIME_W-1:0] r_now, r_peak, r_latest;
    logic [SUM_W-1:0]  r_sum;

    // Result register
    msfd_pkg::t_result r_res;
    logic              r_out_valid;

    logic [TIME_W-1:0] eff_free;
    logic [CNT_W-1:0]  eff_cnt;
    logic [TIME_W:0]   end_sum;
    logic [SUM_W:0]    wait_acc;
    logic [SUM_W-1:0]  n_sum;
    logic [TIME_W-1:0] n_peak, n_latest;

    // Entries never written read as zero
    assign eff_free = r_rd_vbit ? r_rd_free : '0;
    assign eff_cnt  = r_rd_vbit ? r_rd_cnt  : '0;

    // Saturating end time and wait sum
    assign end_sum  = {1'b0, r_now} + {{(TIME_W + 1 - SVC_W){1'b0}}, r_svc};
    assign wait_acc = {1'b0, r_sum} + {{(SUM_W + 1 - TIME_W){1'b0}}, r_wait};
    assign n_sum    = wait_acc[SUM_W] ? {SUM_W{1'b1}} : wait_acc[SUM_W-1:0];
    assign n_peak   = (r_wait > r_peak)  ? r_wait : r_peak;
    assign n_latest = (r_end > r_latest) ? r_end  : r_latest;

    // Table memory: one read port for the scan, one write port for the update
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            mem_free[r_pick] <= r_end;
            mem_cnt[r_pick]  <= r_cnt_new;
        end
        if (i_cmd.rd_en) begin
            r_rd_free <= mem_free[i_rd_addr];
            r_rd_cnt  <= mem_cnt[i_rd_addr];
            r_rd_vbit <= r_valid[i_rd_addr];
            r_rd_idx  <= i_rd_addr;
        end
    end

    // Payload pipeline: capture, scan trackers, calc and commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_arr      <= i_arrival_time;
            r_svc      <= i_service_time;
            r_t        <= (i_arrival_time > r_now) ? i_arrival_time : r_now;
            r_have_min <= 1'b0;
            r_found    <= 1'b0;
        end else if (r_rd_vld) begin
            // first server already free at max(now, arrival)
            if (!r_found && (eff_free <= r_t)) begin
                r_found    <= 1'b1;
                r_free_idx <= r_rd_idx;
                r_free_cnt <= eff_cnt;
            end
            // earliest free time, lowest index on a tie
            if (!r_have_min || (eff_free < r_min)) begin
                r_have_min <= 1'b1;
                r_min      <= eff_free;
                r_min_idx  <= r_rd_idx;
                r_min_cnt  <= eff_cnt;
            end
        end
        if (i_cmd.calc) begin
            r_pick <= r_found ? r_free_idx : r_min_idx;
            r_cnt  <= r_found ? r_free_cnt : r_min_cnt;
        end
        if (i_cmd.commit) begin
            r_end     <= end_sum[TIME_W] ? {TIME_W{1'b1}} : end_sum[TIME_W-1:0];
            r_wait    <= r_now - r_arr;
            r_cnt_new <= (r_cnt == {CNT_W{1'b1}}) ? r_cnt : r_cnt + 1'b1;
        end
        if (i_cmd.finish) begin
            r_res.server_index <= msfd_pkg::IDX_OUT_W'(r_pick);
            r_res.start_time   <= r_now;
            r_res.job_wait     <= r_wait;
            r_res.server_jobs  <= r_cnt_new;
            r_res.total_wait   <= n_sum;
            r_res.max_wait     <= n_peak;
            r_res.finish_time  <= n_latest;
        end
    end

    // State with reset: valid bits, current time, totals, handshake flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_rd_vld    <= 1'b0;
            r_now       <= '0;
            r_sum       <= '0;
            r_peak      <= '0;
            r_latest    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            if (i_cmd.calc) begin
                r_now <= r_found ? r_t : r_min;
            end
            if (i_cmd.finish) begin
                r_valid[r_pick] <= 1'b1;
                r_sum           <= n_sum;
                r_peak          <= n_peak;
                r_latest        <= n_latest;
                r_out_valid     <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_res          = r_res;

endmodule

@@ hw/rtl/multi_server_fifo_dispatcher_core.sv @@
// Multi-server dispatcher: jobs go to the lowest-numbered server free at the
// current time, which first advances to the job's arrival and, if no server is
// free then, to the earliest server free time. One job is in flight at a time.
// The server table is scanned one entry per cycle through a single registered
// read port, then a drain state brings in the last entry and the calc, commit
// and finish states settle the time, form the end time and wait, and write
// back. The result sits in an output register, so the next job can be accepted
// while it waits to be taken; a job that finishes while the previous result is
// still held waits until that result is taken. Server count is clamped to
// 1..MAX_SERVERS; state and totals clear at reset, no clearing pass.
module multi_server_fifo_dispatcher_core #(
    parameter int MAX_SERVERS = msfd_pkg::DEF_MAX_SERVERS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // tdata: arrival_time[31:0], service_time[47:32]
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [msfd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // tdata: server_index[3:0], start_time[35:4], job_wait[67:36],
    // server_jobs[83:68], total_wait[131:84], max_wait[163:132],
    // finish_time[195:164], zero[199:196]
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [msfd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // server_count write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [msfd_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int IDXW  = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int CMPW  = (IDXW + 1 > msfd_pkg::CFG_W) ? IDXW + 1 : msfd_pkg::CFG_W;
    localparam int PAD_W = msfd_pkg::OUT_TDATA_W - $bits(msfd_pkg::t_result);

    msfd_pkg::t_cmd    cmd;
    msfd_pkg::t_sts    sts;
    msfd_pkg::t_result res;
    logic [IDXW-1:0]   rd_addr;
    logic [IDXW-1:0]   r_last, n_last;
    logic [CMPW-1:0]   cfg_ext, k_eff;

    // Server count register, kept as the index of the last server in use
    assign cfg_ext = CMPW'(i_cfg_data);
    always_comb begin
        if (cfg_ext == '0) begin
            k_eff = CMPW'(1);
        end else if (cfg_ext > CMPW'(MAX_SERVERS)) begin
            k_eff = CMPW'(MAX_SERVERS);
        end else begin
            k_eff = cfg_ext;
        end
        n_last = IDXW'(k_eff - 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
        end else if (i_cfg_valid) begin
            r_last <= n_last;
        end
    end

    assign o_cfg_ready = 1'b1;

    msfd_ctrl #(
        .MAX_SERVERS (MAX_SERVERS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_last     (r_last),
        .o_cmd      (cmd),
        .o_rd_addr  (rd_addr),
        .i_sts      (sts)
    );

    msfd_dp #(
        .MAX_SERVERS (MAX_SERVERS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_rd_addr      (rd_addr),
        .i_arrival_time (s_axis_tdata[31:0]),
        .i_service_time (s_axis_tdata[47:32]),
        .o_sts          (sts),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_res          (res)
    );

    // Result packing, first field in the lowest bits
    assign m_axis_tdata = {{PAD_W{1'b0}}, res.finish_time, res.max_wait, res.total_wait,
                           res.server_jobs, res.job_wait, res.start_time, res.server_index};

endmodule

@@ hw/rtl/msfd_checker.sv @@
// Port-level checker for the dispatcher, bound to the top level
`include "multi_server_fifo_dispatcher_core_assert.svh"

module msfd_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          s_axis_tvalid,
    input logic          s_axis_tready,
    input logic          m_axis_tvalid,
    input logic          m_axis_tready,
    input logic [199:0]  m_axis_tdata
);

    // A stalled result holds its value
    `MSFD_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")

    // One job in flight: no second item straight after an accepted one
    `MSFD_ASSERT_NXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready right after accept")

    // Wait never exceeds the start time
    `MSFD_ASSERT_IMP(a_wait_le_start, m_axis_tvalid, m_axis_tdata[67:36] <= m_axis_tdata[35:4], "wait above start time")

    // Peak wait is bounded by the running total
    `MSFD_ASSERT_IMP(a_peak_le_total, m_axis_tvalid, {16'b0, m_axis_tdata[163:132]} <= m_axis_tdata[131:84], "peak wait above total")

    // Latest finish is never before this job's start
    `MSFD_ASSERT_IMP(a_finish_ge_start, m_axis_tvalid, m_axis_tdata[195:164] >= m_axis_tdata[35:4], "finish before start")

endmodule

bind multi_server_fifo_dispatcher_core msfd_checker u_msfd_checker (.*);
